/* rtl/cfd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfd_pkg
// types and constants shared by the control frame deframer modules
// ---------------------------------------------------------------------------
package cfd_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'h7E;
	localparam logic [7:0] SECOND_BYTE  = 8'h80;
	localparam logic [7:0] TRAILER_BYTE = 8'h0D;

	localparam logic [7:0] POS_HUNT     = 8'd0;
	localparam logic [7:0] POS_SECOND   = 8'd1;
	localparam logic [7:0] POS_TRIGGER  = 8'd2;
	localparam logic [7:0] POS_START    = 8'd3;
	localparam logic [7:0] POS_END      = 8'd4;
	localparam logic [7:0] POS_CURRENT  = 8'd5;
	localparam logic [7:0] POS_NEXT     = 8'd6;
	localparam logic [7:0] POS_EM_CODE  = 8'd8;
	localparam logic [7:0] POS_OPEN     = 8'd9;
	localparam logic [7:0] POS_VOLUME   = 8'd14;
	localparam logic [7:0] POS_TEMPLATE = 8'd15;
	localparam logic [7:0] POS_LINE     = 8'd16;
	localparam logic [7:0] POS_YEAR     = 8'd17;
	localparam logic [7:0] POS_MONTH    = 8'd18;
	localparam logic [7:0] POS_DAY      = 8'd19;
	localparam logic [7:0] POS_HOUR     = 8'd20;
	localparam logic [7:0] POS_MINUTE   = 8'd21;
	localparam logic [7:0] POS_SECOND_T = 8'd22;
	localparam logic [7:0] POS_LIGHT    = 8'd42;
	localparam logic [7:0] POS_EM_TYPE  = 8'd127;
	localparam logic [7:0] POS_LEN_LO   = 8'd128;
	localparam logic [7:0] POS_LEN_HI   = 8'd129;
	localparam logic [7:0] POS_TRAILER  = 8'd130;
	localparam logic [7:0] POS_PAYLOAD  = 8'd131;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_WORD   = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [39:0]  route;
		logic [15:0]  alarm;
		logic [31:0]  display;
		logic [47:0]  date_time;
		logic [7:0]   emergency_type;
		logic [15:0]  payload_words;
		logic [15:0]  word_value;
		logic [7:0]   word_index;
		logic         last;
	} result_t;

endpackage

/* rtl/control_frame_deframer_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// control_frame_deframer_unit
// a result is registered and appears on the master side in the cycle after its byte
// throughput: one byte per cycle while the output is not stalled, set by the single parser stage
// a new byte is taken whenever the result register is empty or being drained
// reset: asynchronous, clears frame position (hunting), stores and output valid
// ---------------------------------------------------------------------------
module control_frame_deframer_unit import cfd_pkg::*; #(
	parameter int MAX_WORDS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// route, alarm, display, date_time, emergency_type, payload_words,
	// word_value, word_index
	output logic [183:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // kind
	output logic         m_axis_tlast    // last
);

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t res_out;

	assign accept = s_axis_tvalid && s_axis_tready;

	cfd_parser #(
		.MAX_WORDS (MAX_WORDS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_en     (accept),
		.rx_byte   (s_axis_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	cfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && res_valid),
		.res_in    (res),
		.can_take  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_out   (res_out)
	);

	assign m_axis_tdata = {res_out.word_index, res_out.word_value, res_out.payload_words,
		res_out.emergency_type, res_out.date_time, res_out.display, res_out.alarm,
		res_out.route};
	assign m_axis_tuser = res_out.kind;
	assign m_axis_tlast = res_out.last;

endmodule

/* rtl/cfd_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfd_parser
// frame position tracking, header capture and payload word assembly
// ---------------------------------------------------------------------------
module cfd_parser import cfd_pkg::*; #(
	parameter int MAX_WORDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_en,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	output result_t     res
);

	localparam logic [16:0] MaxWordsW = 17'(MAX_WORDS);

	logic [7:0]  pos_q, pos_d;
	logic [39:0] route_q, route_d;
	logic [15:0] alarm_q, alarm_d;
	logic [31:0] display_q, display_d;
	logic [47:0] clock_q, clock_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] length_q, length_d;
	logic [16:0] cnt_q, cnt_d;
	logic [7:0]  low_q, low_d;

	logic [16:0] total;
	logic [16:0] cnt_inc;
	logic [15:0] idx;
	logic        final_word;

	assign total      = {length_q, 1'b0};
	assign cnt_inc    = cnt_q + 17'd1;
	assign idx        = cnt_q[16:1];
	assign final_word = (cnt_inc == total);

	always_comb begin
		pos_d     = pos_q;
		route_d   = route_q;
		alarm_d   = alarm_q;
		display_d = display_q;
		clock_d   = clock_q;
		type_d    = type_q;
		length_d  = length_q;
		cnt_d     = cnt_q;
		low_d     = low_q;
		res_valid = 1'b0;
		res       = '0;
		res.kind  = KIND_HEADER;

		case (pos_q)
			POS_HUNT: begin
				if (rx_byte == SYNC_BYTE) begin
					route_d   = '0;
					alarm_d   = '0;
					display_d = '0;
					clock_d   = '0;
					type_d    = '0;
					length_d  = '0;
					cnt_d     = '0;
					low_d     = '0;
					pos_d     = POS_SECOND;
				end
			end
			POS_SECOND: begin
				pos_d = (rx_byte == SECOND_BYTE) ? POS_TRIGGER : POS_HUNT;
			end
			POS_TRAILER: begin
				if (rx_byte != TRAILER_BYTE) begin
					pos_d = POS_HUNT;
				end else begin
					res_valid          = 1'b1;
					res.route          = route_q;
					res.alarm          = alarm_q;
					res.display        = display_q;
					res.date_time      = clock_q;
					res.emergency_type = type_q;
					res.payload_words  = length_q;
					if (type_q == 8'd0 || length_q == 16'd0) begin
						pos_d    = POS_HUNT;
						res.last = 1'b1;
					end else begin
						pos_d = POS_PAYLOAD;
						cnt_d = '0;
					end
				end
			end
			POS_PAYLOAD: begin
				if (cnt_q >= total) begin
					pos_d = POS_HUNT;
				end else begin
					cnt_d = cnt_inc;
					if (!cnt_q[0]) begin
						low_d = rx_byte;
					end else begin
						if (final_word) begin
							pos_d = POS_HUNT;
						end
						if ({1'b0, idx} < MaxWordsW) begin
							res_valid      = 1'b1;
							res.kind       = KIND_WORD;
							res.word_value = {rx_byte, low_q};
							res.word_index = idx[7:0];
							res.last       = final_word;
						end else if (final_word) begin
							res_valid = 1'b1;
							res.kind  = KIND_END;
							res.last  = 1'b1;
						end
					end
				end
			end
			default: begin
				if (pos_q > POS_PAYLOAD) begin
					pos_d = POS_HUNT;
				end else begin
					pos_d = pos_q + 8'd1;
					case (pos_q)
						POS_TRIGGER:  route_d[39:32]   = rx_byte;
						POS_START:    route_d[31:24]   = rx_byte;
						POS_END:      route_d[23:16]   = rx_byte;
						POS_CURRENT:  route_d[15:8]    = rx_byte;
						POS_NEXT:     route_d[7:0]     = rx_byte;
						POS_EM_CODE:  alarm_d[15:8]    = rx_byte;
						POS_OPEN:     alarm_d[7:0]     = rx_byte;
						POS_VOLUME:   display_d[31:24] = rx_byte;
						POS_TEMPLATE: display_d[23:16] = rx_byte;
						POS_LINE:     display_d[15:8]  = rx_byte;
						POS_LIGHT:    display_d[7:0]   = rx_byte;
						POS_YEAR:     clock_d[47:40]   = rx_byte;
						POS_MONTH:    clock_d[39:32]   = rx_byte;
						POS_DAY:      clock_d[31:24]   = rx_byte;
						POS_HOUR:     clock_d[23:16]   = rx_byte;
						POS_MINUTE:   clock_d[15:8]    = rx_byte;
						POS_SECOND_T: clock_d[7:0]     = rx_byte;
						POS_EM_TYPE:  type_d           = rx_byte;
						POS_LEN_LO:   length_d         = {8'd0, rx_byte};
						POS_LEN_HI:   length_d[15:8]   = rx_byte;
						default: ;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_HUNT;
			route_q   <= '0;
			alarm_q   <= '0;
			display_q <= '0;
			clock_q   <= '0;
			type_q    <= '0;
			length_q  <= '0;
			cnt_q     <= '0;
			low_q     <= '0;
		end else if (in_en) begin
			pos_q     <= pos_d;
			route_q   <= route_d;
			alarm_q   <= alarm_d;
			display_q <= display_d;
			clock_q   <= clock_d;
			type_q    <= type_d;
			length_q  <= length_d;
			cnt_q     <= cnt_d;
			low_q     <= low_d;
		end
	end

endmodule

/* rtl/cfd_out_reg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfd_out_reg
// result register between the parser and the output stream
// ---------------------------------------------------------------------------
module cfd_out_reg import cfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    can_take,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
